// ----- sv/cgb_pkg.sv -----
// Shared types, constants and register codes of the clipped glyph row blitter.
`timescale 1ns / 1ps

package cgb_pkg;

    // Rows per glyph; the row counter wraps after this many requests.
    localparam int GLYPH_ROWS  = 12;
    // Columns per glyph row, fixed by the left input byte and the upper nibble of the right one.
    localparam int GLYPH_COLS  = 12;
    localparam int COL_W       = $clog2(GLYPH_COLS);
    localparam int ROW_W       = 4;
    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_X_MIN = 3'd0,
        REG_CLIP_X_MAX = 3'd1,
        REG_CLIP_Y_MIN = 3'd2,
        REG_CLIP_Y_MAX = 3'd3,
        REG_FRAME_BASE = 3'd4,
        REG_ROW_PITCH  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] clip_x_min;
        logic signed [15:0] clip_x_max;
        logic signed [15:0] clip_y_min;
        logic signed [15:0] clip_y_max;
        logic        [31:0] frame_base;
        logic        [15:0] row_pitch;
    } cfg_t;

    // One classified row: surviving pixel columns, address of column 0, ink.
    typedef struct packed {
        logic [GLYPH_COLS-1:0] mask;
        logic [31:0]           row_base;
        logic [15:0]           ink;
    } row_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- sv/cgb_front.sv -----
// Front end: accepts glyph rows, clips them and computes the row base address.
`timescale 1ns / 1ps

module cgb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cgb_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_left_bits,
    input  logic [7:0]           s_right_bits,
    input  logic signed [15:0]   s_origin_x,
    input  logic signed [15:0]   s_origin_y,
    input  logic [15:0]          s_ink_color,
    output logic                 q_push,
    output cgb_pkg::row_t        q_data,
    input  cgb_pkg::q_stat_t     q_stat
);

    localparam int NC = cgb_pkg::GLYPH_COLS;

    logic [cgb_pkg::ROW_W-1:0] row_reg, row_next;
    logic                      st_valid_reg, st_valid_next;
    logic [NC-1:0]             st_mask_reg;
    logic [31:0]               st_prod_reg;
    logic signed [15:0]        st_ox_reg;
    logic [15:0]               st_ink_reg;

    logic [NC-1:0]             bits;
    logic [NC-1:0]             mask;
    logic signed [16:0]        y_pos;
    logic signed [16:0]        x_pos;
    logic                      y_in;
    logic signed [33:0]        prod_full;
    logic                      accept;
    logic                      st_adv;
    logic [31:0]               off_sum;

    always_comb begin
        bits  = {s_left_bits, s_right_bits[7:4]};
        y_pos = $signed({s_origin_y[15], s_origin_y}) + $signed({13'd0, row_reg});
        y_in  = (y_pos >= $signed({cfg.clip_y_min[15], cfg.clip_y_min}))
             && (y_pos <= $signed({cfg.clip_y_max[15], cfg.clip_y_max}));
        mask  = '0;
        x_pos = '0;
        for (int c = 0; c < NC; c++) begin
            x_pos = $signed({s_origin_x[15], s_origin_x}) + $signed(17'(c));
            mask[NC-1-c] = bits[NC-1-c] && y_in
                && (x_pos >= $signed({cfg.clip_x_min[15], cfg.clip_x_min}))
                && (x_pos <= $signed({cfg.clip_x_max[15], cfg.clip_x_max}));
        end
        prod_full = y_pos * $signed({1'b0, cfg.row_pitch});
    end

    // Drop rows with no surviving pixel; otherwise wait for queue room.
    assign st_adv  = st_valid_reg && ((st_mask_reg == '0) || !q_stat.full);
    assign s_ready = !st_valid_reg || st_adv;
    assign accept  = s_valid && s_ready;

    always_comb begin
        off_sum         = st_prod_reg + {{16{st_ox_reg[15]}}, st_ox_reg};
        q_push          = st_adv && (st_mask_reg != '0);
        q_data.mask     = st_mask_reg;
        q_data.row_base = cfg.frame_base + {off_sum[30:0], 1'b0};
        q_data.ink      = st_ink_reg;
    end

    always_comb begin
        row_next      = row_reg;
        st_valid_next = st_valid_reg;
        if (accept) begin
            row_next = (row_reg == cgb_pkg::ROW_W'(cgb_pkg::GLYPH_ROWS - 1))
                     ? '0 : row_reg + 1'b1;
            st_valid_next = 1'b1;
        end else if (st_adv) begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            row_reg      <= row_next;
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_mask_reg <= mask;
            st_prod_reg <= prod_full[31:0];
            st_ox_reg   <= s_origin_x;
            st_ink_reg  <= s_ink_color;
        end
    end

endmodule

// ----- sv/cgb_queue.sv -----
// Short queue of classified rows between the front and back ends.
`timescale 1ns / 1ps

module cgb_queue #(
    parameter int DEPTH = cgb_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cgb_pkg::row_t    push_data,
    input  logic             pop,
    output cgb_pkg::row_t    head,
    output cgb_pkg::q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cgb_pkg::row_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full && !pop |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

// ----- sv/cgb_back.sv -----
// Back end: walks a row's pixel mask and issues one framebuffer write per cycle while m_ready and the queue allow.
`timescale 1ns / 1ps

module cgb_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  cgb_pkg::row_t    q_head,
    input  cgb_pkg::q_stat_t q_stat,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_write_address,
    output logic [15:0]      m_write_value,
    output logic             m_row_last
);

    localparam int NC = cgb_pkg::GLYPH_COLS;
    localparam int CW = cgb_pkg::COL_W;

    logic [NC-1:0] cur_mask_reg, cur_mask_next;
    logic [31:0]   cur_base_reg;
    logic [15:0]   cur_ink_reg;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_addr_reg;
    logic [15:0]   m_value_reg;
    logic          m_last_reg;

    logic [CW-1:0] col;
    logic [NC-1:0] clear_mask;
    logic [NC-1:0] mask_after;
    logic          emit;

    always_comb begin
        // Leftmost remaining column wins.
        col = '0;
        for (int c = NC - 1; c >= 0; c--) begin
            if (cur_mask_reg[NC-1-c]) begin
                col = CW'(c);
            end
        end
        clear_mask    = cur_mask_reg & ~(NC'(1) << (CW'(NC - 1) - col));
        emit          = (cur_mask_reg != '0) && (!m_valid_reg || m_ready);
        mask_after    = emit ? clear_mask : cur_mask_reg;
        q_pop         = !q_stat.empty && (mask_after == '0);
        cur_mask_next = q_pop ? q_head.mask : mask_after;
        m_valid_next  = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_mask_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            cur_mask_reg <= cur_mask_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_base_reg <= q_head.row_base;
            cur_ink_reg  <= q_head.ink;
        end
        if (emit) begin
            m_addr_reg  <= cur_base_reg + {{(31 - CW){1'b0}}, col, 1'b0};
            m_value_reg <= cur_ink_reg;
            m_last_reg  <= (clear_mask == '0);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_address = m_addr_reg;
    assign m_write_value   = m_value_reg;
    assign m_row_last      = m_last_reg;

    a_no_empty_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head.mask != '0)
        else $error("queued row carries no pixel");

    a_load_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> cur_mask_reg != '0)
        else $error("loaded row lost its pixels");

endmodule

// ----- sv/clipped_mono_glyph_blit.sv -----
// Top level of the clipped monochrome glyph row blitter.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    left_bits, right_bits, origin_x, origin_y, ink_color
//  m_       out        m_valid/m_ready    write_address, write_value, row_last
//  cfg_     in         cfg_we             cfg_index, cfg_data (no read-back)
//
//  A row request is clipped and registered in the front end; the back end issues one
//  write per cycle while m_ready and the queue allow it, at most 12 writes per row,
//  so the single write port of the back end sets the pace.
//  From accept to first write: front stage, queue, back end row register, output register.
//  Reset (aresetn, synchronous) clears the row counter, the queue, the pixel
//  walker and m_valid, and loads the register defaults.
//  Stalls on m_ready fill the queue; s_ready drops only once it is full.

module clipped_mono_glyph_blit #(
    parameter int QUEUE_DEPTH = cgb_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [cgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cgb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // glyph row requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_left_bits,
    input  logic [7:0]                        s_right_bits,
    input  logic signed [15:0]                s_origin_x,
    input  logic signed [15:0]                s_origin_y,
    input  logic [15:0]                       s_ink_color,
    // framebuffer writes
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [31:0]                       m_write_address,
    output logic [15:0]                       m_write_value,
    output logic                              m_row_last
);

    cgb_pkg::cfg_t    cfg_reg;
    cgb_pkg::row_t    q_in, q_head;
    cgb_pkg::q_stat_t q_stat;
    logic             q_push, q_pop;

    // Register file: writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip_x_min <= '0;
            cfg_reg.clip_x_max <= '0;
            cfg_reg.clip_y_min <= '0;
            cfg_reg.clip_y_max <= '0;
            cfg_reg.frame_base <= '0;
            cfg_reg.row_pitch  <= 16'd1;
        end else if (cfg_we) begin
            case (cgb_pkg::reg_idx_t'(cfg_index))
                cgb_pkg::REG_CLIP_X_MIN: cfg_reg.clip_x_min <= cfg_data[15:0];
                cgb_pkg::REG_CLIP_X_MAX: cfg_reg.clip_x_max <= cfg_data[15:0];
                cgb_pkg::REG_CLIP_Y_MIN: cfg_reg.clip_y_min <= cfg_data[15:0];
                cgb_pkg::REG_CLIP_Y_MAX: cfg_reg.clip_y_max <= cfg_data[15:0];
                cgb_pkg::REG_FRAME_BASE: cfg_reg.frame_base <= cfg_data[31:0];
                cgb_pkg::REG_ROW_PITCH:  cfg_reg.row_pitch  <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Front: clip the row, advance the row counter, form the row base address.
    cgb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_left_bits  (s_left_bits),
        .s_right_bits (s_right_bits),
        .s_origin_x   (s_origin_x),
        .s_origin_y   (s_origin_y),
        .s_ink_color  (s_ink_color),
        .q_push       (q_push),
        .q_data       (q_in),
        .q_stat       (q_stat)
    );

    // Queue: hold classified rows so either side may stall alone.
    cgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // Back: issue one pixel write per cycle through the output register while m_ready allows.
    cgb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_head          (q_head),
        .q_stat          (q_stat),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_value   (m_write_value),
        .m_row_last      (m_row_last)
    );

endmodule

// ----- tb/clipped_mono_glyph_blit_test.sv -----
// Self-checking testbench of the clipped glyph row blitter: directed and random row requests against a predictor.
`timescale 1ns / 1ps

module clipped_mono_glyph_blit_test;

    // Register indexes that decode to nothing; writes to them must be ignored.
    localparam logic [cgb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [cgb_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // Idle cycles (nothing accepted while work is outstanding) before giving up.
    localparam int STALL_LIMIT  = 4000;
    // Length of the deliberate output hold-off.
    localparam int LONG_HOLD    = 150;
    // Cycles to let a request with no writes leave the pipeline.
    localparam int SETTLE       = 8;
    localparam int RANDOM_PHASES = 5;
    localparam int ROWS_PER_PHASE = 18;
    // Full rows offered while the output is held off.
    localparam int PRESSURE_ROWS = 8;

    typedef struct {
        logic [7:0]         left_bits;
        logic [7:0]         right_bits;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        ink_color;
    } row_req_t;

    typedef struct {
        logic [31:0] write_address;
        logic [15:0] write_value;
        logic        row_last;
    } pixel_write_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [cgb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cgb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_left_bits  = '0;
    logic [7:0]                     s_right_bits = '0;
    logic signed [15:0]             s_origin_x   = '0;
    logic signed [15:0]             s_origin_y   = '0;
    logic [15:0]                    s_ink_color  = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [31:0]                    m_write_address;
    logic [15:0]                    m_write_value;
    logic                           m_row_last;

    clipped_mono_glyph_blit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_left_bits     (s_left_bits),
        .s_right_bits    (s_right_bits),
        .s_origin_x      (s_origin_x),
        .s_origin_y      (s_origin_y),
        .s_ink_color     (s_ink_color),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_value   (m_write_value),
        .m_row_last      (m_row_last)
    );

    always #2 aclk = ~aclk;

    // Shadow copy of the register file and the row counter.
    logic signed [15:0]        clip_x_lo = 16'sd0;
    logic signed [15:0]        clip_x_hi = 16'sd0;
    logic signed [15:0]        clip_y_lo = 16'sd0;
    logic signed [15:0]        clip_y_hi = 16'sd0;
    logic [31:0]               base_addr = 32'd0;
    logic [15:0]               pitch_px  = 16'd1;
    logic [cgb_pkg::ROW_W-1:0] row_idx   = '0;

    row_req_t     pending_rows[$];
    pixel_write_t expected_writes[$];

    int rows_queued    = 0;
    int rows_accepted  = 0;
    int writes_checked = 0;
    int reg_writes     = 0;
    int mismatches     = 0;
    bit long_hold_done = 1'b0;
    bit pressure_phase = 1'b0;

    // Expand one accepted row request into the pixel writes it must cause,
    // then advance the row counter whether or not anything survived the clip.
    function automatic void predict_row_writes(input row_req_t r);
        logic [11:0] glyph;
        logic [31:0] line_off;
        pixel_write_t w;
        int y;
        int x;
        int n;
        glyph = {r.left_bits, r.right_bits[7:4]};
        // Coordinates are exact: no 16-bit wrap before the clip compare.
        y = int'(r.origin_y) + int'(row_idx);
        n = 0;
        if (y >= int'(clip_y_lo) && y <= int'(clip_y_hi)) begin
            line_off = 32'(y) * {16'd0, pitch_px};
            for (int col = 0; col < cgb_pkg::GLYPH_COLS; col++) begin
                x = int'(r.origin_x) + col;
                if (glyph[11 - col] && x >= int'(clip_x_lo) && x <= int'(clip_x_hi)) begin
                    w.write_address = base_addr + (line_off + 32'(x)) * 32'd2;
                    w.write_value   = r.ink_color;
                    w.row_last      = 1'b0;
                    expected_writes.push_back(w);
                    n++;
                end
            end
            if (n > 0) begin
                expected_writes[expected_writes.size() - 1].row_last = 1'b1;
            end
        end
        if (int'(row_idx) + 1 >= cgb_pkg::GLYPH_ROWS) begin
            row_idx = '0;
        end else begin
            row_idx = row_idx + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pop pending requests in bursts with random gaps.
    // Hold valid and payload steady until the block takes the request.
    // ------------------------------------------------------------------
    int       burst_left = 0;
    int       gap_left   = 0;
    row_req_t next_row;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_row_writes(next_row);
                rows_accepted++;
            end
            // The slot is free once nothing is offered or the offer was just taken.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_rows.size() > 0) begin
                    next_row = pending_rows.pop_front();
                    s_left_bits  <= next_row.left_bits;
                    s_right_bits <= next_row.right_bits;
                    s_origin_x   <= next_row.origin_x;
                    s_origin_y   <= next_row.origin_y;
                    s_ink_color  <= next_row.ink_color;
                    s_valid      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Start a new burst; some bursts run back to back with no gap.
                        burst_left = $urandom_range(0, 9);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Write monitor: check each accepted write against the oldest
    // expectation and shape m_ready with a stall pattern of its own.
    // ------------------------------------------------------------------
    int           stall_mode  = 0;
    int           mode_cycles = 0;
    int           hold_left   = 0;
    int           cycle_count = 0;
    pixel_write_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            cycle_count++;
            if (m_valid && m_ready) begin
                writes_checked++;
                if (expected_writes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] unexpected write: addr=%h value=%h last=%b",
                                 $realtime, m_write_address, m_write_value, m_row_last);
                    end
                end else begin
                    want = expected_writes.pop_front();
                    if (m_write_address !== want.write_address ||
                        m_write_value   !== want.write_value ||
                        m_row_last      !== want.row_last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] write %0d: expected addr=%h value=%h last=%b",
                                     $realtime, writes_checked, want.write_address,
                                     want.write_value, want.row_last);
                            $display("            got      addr=%h value=%h last=%b",
                                     m_write_address, m_write_value, m_row_last);
                        end
                    end
                end
            end

            // Pick a new stall pattern whenever mode_cycles runs out.
            if (mode_cycles == 0) begin
                stall_mode  = $urandom_range(0, 3);
                mode_cycles = 64;
            end
            mode_cycles--;

            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && pressure_phase) begin
                // Hold off long enough that the queue fills and s_ready drops
                // while the driver keeps offering requests.
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (cycle_count % 3 == 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count busy cycles in which neither channel moves anything.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((rows_accepted != rows_queued || expected_writes.size() != 0) &&
            !(s_valid && s_ready) && !(m_valid && m_ready)) begin
            idle_cycles++;
        end else begin
            idle_cycles = 0;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no progress for %0d cycles, %0d writes still expected",
                     $realtime, idle_cycles, expected_writes.size());
            $display("clipped_mono_glyph_blit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Write one register and mirror it into the shadow copy.
    task automatic write_reg(input logic [cgb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            cgb_pkg::REG_CLIP_X_MIN: clip_x_lo = data[15:0];
            cgb_pkg::REG_CLIP_X_MAX: clip_x_hi = data[15:0];
            cgb_pkg::REG_CLIP_Y_MIN: clip_y_lo = data[15:0];
            cgb_pkg::REG_CLIP_Y_MAX: clip_y_hi = data[15:0];
            cgb_pkg::REG_FRAME_BASE: base_addr = data;
            cgb_pkg::REG_ROW_PITCH:  pitch_px  = data[15:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Program the whole register file; junk in the upper data bits of writes to 16-bit registers.
    task automatic program_window(input int xmin, input int xmax, input int ymin,
                                  input int ymax, input logic [31:0] base, input int pitch);
        write_reg(cgb_pkg::REG_CLIP_X_MIN, {16'($urandom()), 16'(xmin)});
        write_reg(cgb_pkg::REG_CLIP_X_MAX, {16'($urandom()), 16'(xmax)});
        write_reg(cgb_pkg::REG_CLIP_Y_MIN, {16'($urandom()), 16'(ymin)});
        write_reg(cgb_pkg::REG_CLIP_Y_MAX, {16'($urandom()), 16'(ymax)});
        write_reg(cgb_pkg::REG_FRAME_BASE, base);
        write_reg(cgb_pkg::REG_ROW_PITCH,  {16'($urandom()), 16'(pitch)});
    endtask

    task automatic queue_row(input int lb, input int rb, input int ox, input int oy,
                             input int ink);
        row_req_t r;
        r.left_bits  = 8'(lb);
        r.right_bits = 8'(rb);
        r.origin_x   = 16'(ox);
        r.origin_y   = 16'(oy);
        r.ink_color  = 16'(ink);
        pending_rows.push_back(r);
        rows_queued++;
    endtask

    // Block until every request is taken and every write has come out, then
    // let a trailing request that makes no writes drain from the pipeline.
    task automatic wait_drained();
        while (rows_accepted != rows_queued || expected_writes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    int win_x;
    int win_y;
    int span_x;
    int span_y;
    int pitch_sel;
    int lb;

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: only pixel (0,0) is inside the clip, base 0, pitch 1.
        queue_row(8'h80, 8'h00, 0, 0, 16'h1234);
        queue_row(8'hff, 8'hf0, -1, -1, 16'h4321);
        wait_drained();

        // Widest clip, base near the top of memory so addresses wrap,
        // and the largest pitch.
        program_window(-32768, 32767, -32768, 32767, 32'hffff_fff0, 65535);
        queue_row(8'hff, 8'hff, 0, 0, 16'hffff);
        queue_row(8'hff, 8'h0f, 32767 - 5, -32768, 16'h0000);  // x runs past the top
        queue_row(8'hff, 8'hf0, -32768, 32767, 16'haaaa);      // y may run past the top
        queue_row(8'h00, 8'h00, 10, 10, 16'h5555);             // blank row
        queue_row(8'h00, 8'h0f, 20, 20, 16'h7777);             // only the ignored nibble
        queue_row(8'haa, 8'h50, -1, -1, 16'h5555);
        queue_row(8'h01, 8'h10, 100, 200, 16'h0001);
        queue_row(8'h80, 8'h80, 32767, -32768, 16'h8000);
        queue_row(8'h55, 8'ha0, -32768, -32768, 16'h00ff);
        wait_drained();

        // Empty clip rectangle, first on x, then on y.
        program_window(5, 4, -32768, 32767, 32'h0000_1000, 64);
        queue_row(8'hff, 8'hff, 0, 0, 16'h1111);
        queue_row(8'hff, 8'hff, 4, 4, 16'h2222);
        wait_drained();
        program_window(-32768, 32767, 1, 0, 32'h0000_1000, 64);
        queue_row(8'hff, 8'hff, 0, 0, 16'h3333);
        queue_row(8'hff, 8'hff, 0, -5, 16'h4444);
        wait_drained();

        // Zero pitch with a narrow window so rows are clipped in part.
        program_window(3, 8, -20, 20, 32'h0000_2000, 0);
        queue_row(8'hff, 8'hff, 0, 0, 16'hbeef);
        queue_row(8'hff, 8'hff, 5, -3, 16'hcafe);
        queue_row(8'h81, 8'h90, -4, 7, 16'h0f0f);
        queue_row(8'hff, 8'hff, 8, 19, 16'hf0f0);
        wait_drained();

        // Writes to unmapped indexes must leave the window untouched.
        write_reg(REG_UNMAPPED_LO, $urandom());
        write_reg(REG_UNMAPPED_HI, $urandom());
        queue_row(8'hff, 8'hff, 0, 0, 16'h6666);
        queue_row(8'hff, 8'hff, 2, 2, 16'h9999);
        wait_drained();

        // Hold off writes while a run of full rows arrives: every row keeps
        // pixels, so the queue fills and s_ready drops with requests on offer.
        program_window(-32768, 32767, -32768, 32767, 32'h0001_0000, 320);
        pressure_phase = 1'b1;
        for (int i = 0; i < PRESSURE_ROWS; i++) begin
            queue_row(8'hff, 8'hf0, 16 * i, 4 * i, 16'h0100 + i);
        end
        wait_drained();
        pressure_phase = 1'b0;

        // Random windows: most origins land near the window so rows are
        // partly clipped; a few are anywhere.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            win_x  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 100) - 50
                                                 : int'(16'sh0 + 16'($urandom()));
            win_y  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 100) - 50
                                                 : int'(16'sh0 + 16'($urandom()));
            span_x = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 30);
            span_y = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 20);
            pitch_sel = $urandom_range(0, 5);
            program_window(win_x, win_x + span_x, win_y, win_y + span_y, $urandom(),
                           (pitch_sel == 0) ? 0 :
                           (pitch_sel == 1) ? 65535 : $urandom_range(1, 2000));
            for (int i = 0; i < ROWS_PER_PHASE; i++) begin
                case ($urandom_range(0, 7))
                    0:       lb = 8'hff;
                    1:       lb = 8'h00;
                    default: lb = $urandom_range(0, 255);
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    queue_row(lb, $urandom_range(0, 255), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
                end else begin
                    queue_row(lb, $urandom_range(0, 255),
                              win_x - 12 + $urandom_range(0, 24 + (span_x < 0 ? 0 : span_x)),
                              win_y - 11 + $urandom_range(0, 22 + (span_y < 0 ? 0 : span_y)),
                              $urandom_range(0, 65535));
                end
            end
            wait_drained();
        end

        // Count whatever is still owed as a failure.
        mismatches += expected_writes.size();

        $display("Covered %0d row requests and %0d pixel writes over %0d register writes,",
                 rows_accepted, writes_checked, reg_writes);
        $display("including empty and full windows, zero pitch, address wrap and a long stall.");
        if (mismatches == 0) begin
            $display("clipped_mono_glyph_blit: match");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("clipped_mono_glyph_blit: mismatch");
        end
        $finish;
    end

endmodule
